@@ rtl/core/lpmd_pkg.sv @@
// lpmd_pkg: shared types, codes and reset values for the message deframer
// no dependencies; used by every module under rtl/core
`timescale 1ns / 1ps

package lpmd_pkg;

    // header layout defaults
    localparam int ID_BYTES_DEF  = 2;
    localparam int LEN_BYTES_DEF = 2;

    // register reset values
    localparam logic [15:0] LEN_LIMIT_RST     = 16'd2048;
    localparam logic [15:0] HEARTBEAT_ID_RST  = 16'd1023;
    localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd10000;

    // configuration register indexes
    localparam logic [1:0] REG_LEN_LIMIT     = 2'd0;
    localparam logic [1:0] REG_HEARTBEAT_ID  = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    // input word kinds
    localparam logic [1:0] CMD_BYTE     = 2'd0;
    localparam logic [1:0] CMD_TICK     = 2'd1;
    localparam logic [1:0] CMD_LINK_ERR = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_BYTE    = 3'd0;
    localparam logic [2:0] KIND_EMPTY   = 3'd1;
    localparam logic [2:0] KIND_HEART   = 3'd2;
    localparam logic [2:0] KIND_HDR_ERR = 3'd3;
    localparam logic [2:0] KIND_CLOSE   = 3'd4;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_CLOSED  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [15:0] len_limit;
        logic [15:0] heartbeat_id;
        logic [31:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload_byte;
        logic [15:0] message_id;
        logic        last;
    } result_t;

    typedef struct packed {
        logic closed;
        logic timer_armed;
    } status_t;

endpackage

@@ rtl/core/lpmd_cfg_regs.sv @@
// lpmd_cfg_regs: configuration register file (limit, heartbeat id, timeout)
// depends on lpmd_pkg
`timescale 1ns / 1ps

module lpmd_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output lpmd_pkg::cfg_t      cfg
);

    lpmd_pkg::cfg_t cfg_reg;
    lpmd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                lpmd_pkg::REG_LEN_LIMIT:     cfg_next.len_limit     = cfg_data[15:0];
                lpmd_pkg::REG_HEARTBEAT_ID:  cfg_next.heartbeat_id  = cfg_data[15:0];
                lpmd_pkg::REG_TIMEOUT_TICKS: cfg_next.timeout_ticks = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.len_limit     <= lpmd_pkg::LEN_LIMIT_RST;
            cfg_reg.heartbeat_id  <= lpmd_pkg::HEARTBEAT_ID_RST;
            cfg_reg.timeout_ticks <= lpmd_pkg::TIMEOUT_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/core/lpmd_in_reg.sv @@
// lpmd_in_reg: input register stage, holds one word ahead of the framing logic
// depends on lpmd_pkg
`timescale 1ns / 1ps

module lpmd_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic [7:0]          data_byte,
    input  logic                consume,
    output logic                item_valid,
    output lpmd_pkg::item_t     item
);

    logic            valid_reg;
    logic            valid_next;
    lpmd_pkg::item_t item_reg;
    logic            load;

    assign in_ready   = !valid_reg || consume;
    assign load       = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (consume)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.cmd       <= cmd;
            item_reg.data_byte <= data_byte;
        end
    end

endmodule

@@ rtl/core/lpmd_frame_fsm.sv @@
// lpmd_frame_fsm: header assembly, payload count, heartbeat timer and session close
// depends on lpmd_pkg; fed by lpmd_in_reg, drives lpmd_out_reg
`timescale 1ns / 1ps

module lpmd_frame_fsm
#(
    parameter int ID_BYTES  = lpmd_pkg::ID_BYTES_DEF,
    parameter int LEN_BYTES = lpmd_pkg::LEN_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  lpmd_pkg::cfg_t      cfg,
    input  logic                item_valid,
    input  lpmd_pkg::item_t     item,
    input  logic                out_free,
    output logic                consume,
    output logic                res_valid,
    output lpmd_pkg::result_t   res,
    output lpmd_pkg::status_t   status
);

    localparam int HDR_BYTES = ID_BYTES + LEN_BYTES;
    localparam int SHIFT_W   = 8 * (HDR_BYTES - 1);
    localparam int FULL_W    = 8 * HDR_BYTES;
    localparam int ID_W      = 8 * ID_BYTES;
    localparam int LEN_W     = 8 * LEN_BYTES;
    localparam int CNT_W     = $clog2(HDR_BYTES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HDR_BYTES - 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    lpmd_pkg::phase_t   phase_reg, phase_next;
    logic [CNT_W-1:0]   hdr_cnt_reg, hdr_cnt_next;
    logic [SHIFT_W-1:0] hdr_bytes_reg, hdr_bytes_next;
    logic [15:0]        cur_id_reg, cur_id_next;
    logic [15:0]        bytes_left_reg, bytes_left_next;
    logic               armed_reg, armed_next;
    logic [31:0]        timer_reg, timer_next;

    logic [FULL_W-1:0]  hdr_full;
    logic [15:0]        hdr_id;
    logic [15:0]        hdr_len;
    logic               hit;
    lpmd_pkg::result_t  res_c;

    assign consume   = item_valid && out_free;
    assign res_valid = consume && hit;
    assign res       = res_c;

    assign status.closed      = (phase_reg == lpmd_pkg::PH_CLOSED);
    assign status.timer_armed = armed_reg;

    assign hdr_full = {hdr_bytes_reg, item.data_byte};
    assign hdr_len  = 16'(hdr_full[LEN_W-1:0]);
    assign hdr_id   = 16'(hdr_full[FULL_W-1 -: ID_W]);

    always_comb
    begin
        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        hdr_bytes_next  = hdr_bytes_reg;
        cur_id_next     = cur_id_reg;
        bytes_left_next = bytes_left_reg;
        armed_next      = armed_reg;
        timer_next      = timer_reg;
        hit             = 1'b0;
        res_c           = '0;

        if (phase_reg != lpmd_pkg::PH_CLOSED)
        begin
            case (item.cmd)
                lpmd_pkg::CMD_LINK_ERR:
                begin
                    phase_next = lpmd_pkg::PH_CLOSED;
                    armed_next = 1'b0;
                    timer_next = '0;
                    hit        = 1'b1;
                    res_c.kind = lpmd_pkg::KIND_CLOSE;
                    res_c.last = 1'b1;
                end
                lpmd_pkg::CMD_TICK:
                begin
                    if (armed_reg)
                    begin
                        if (timer_reg <= 32'd1)
                        begin
                            phase_next = lpmd_pkg::PH_CLOSED;
                            armed_next = 1'b0;
                            timer_next = '0;
                            hit        = 1'b1;
                            res_c.kind = lpmd_pkg::KIND_CLOSE;
                            res_c.last = 1'b1;
                        end
                        else
                        begin
                            timer_next = timer_reg - 32'd1;
                        end
                    end
                end
                lpmd_pkg::CMD_BYTE:
                begin
                    if (phase_reg == lpmd_pkg::PH_HEADER)
                    begin
                        if (hdr_cnt_reg != CNT_LAST)
                        begin
                            hdr_bytes_next = SHIFT_W'({hdr_bytes_reg, item.data_byte});
                            hdr_cnt_next   = hdr_cnt_reg + CNT_ONE;
                        end
                        else
                        begin
                            hdr_cnt_next     = '0;
                            hdr_bytes_next   = '0;
                            cur_id_next      = hdr_id;
                            hit              = 1'b1;
                            res_c.message_id = hdr_id;
                            res_c.last       = 1'b1;
                            // id and length are both checked against the limit
                            if (hdr_id > cfg.len_limit || hdr_len > cfg.len_limit)
                            begin
                                phase_next = lpmd_pkg::PH_CLOSED;
                                armed_next = 1'b0;
                                timer_next = '0;
                                res_c.kind = lpmd_pkg::KIND_HDR_ERR;
                            end
                            else if (hdr_len == 16'd0)
                            begin
                                bytes_left_next = '0;
                                if (hdr_id == cfg.heartbeat_id)
                                begin
                                    armed_next = 1'b1;
                                    timer_next = cfg.timeout_ticks;
                                    res_c.kind = lpmd_pkg::KIND_HEART;
                                end
                                else
                                begin
                                    res_c.kind = lpmd_pkg::KIND_EMPTY;
                                end
                            end
                            else
                            begin
                                hit             = 1'b0;
                                res_c           = '0;
                                bytes_left_next = hdr_len;
                                phase_next      = lpmd_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                    else
                    begin
                        bytes_left_next  = bytes_left_reg - 16'd1;
                        res_c.message_id = cur_id_reg;
                        if (bytes_left_reg == 16'd1)
                        begin
                            phase_next   = lpmd_pkg::PH_HEADER;
                            hdr_cnt_next = '0;
                            hdr_bytes_next = '0;
                            hit          = 1'b1;
                            res_c.last   = 1'b1;
                            if (cur_id_reg == cfg.heartbeat_id)
                            begin
                                armed_next = 1'b1;
                                timer_next = cfg.timeout_ticks;
                                res_c.kind = lpmd_pkg::KIND_HEART;
                            end
                            else
                            begin
                                res_c.kind         = lpmd_pkg::KIND_BYTE;
                                res_c.payload_byte = item.data_byte;
                            end
                        end
                        else if (cur_id_reg != cfg.heartbeat_id)
                        begin
                            // heartbeat bodies are swallowed
                            hit                = 1'b1;
                            res_c.kind         = lpmd_pkg::KIND_BYTE;
                            res_c.payload_byte = item.data_byte;
                        end
                    end
                end
                default:
                begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= lpmd_pkg::PH_HEADER;
            hdr_cnt_reg    <= '0;
            hdr_bytes_reg  <= '0;
            cur_id_reg     <= '0;
            bytes_left_reg <= '0;
            armed_reg      <= 1'b0;
            timer_reg      <= '0;
        end
        else if (consume)
        begin
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            hdr_bytes_reg  <= hdr_bytes_next;
            cur_id_reg     <= cur_id_next;
            bytes_left_reg <= bytes_left_next;
            armed_reg      <= armed_next;
            timer_reg      <= timer_next;
        end
    end

endmodule

@@ rtl/core/lpmd_out_reg.sv @@
// lpmd_out_reg: result register, holds one result word until taken downstream
// depends on lpmd_pkg
`timescale 1ns / 1ps

module lpmd_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    input  lpmd_pkg::result_t   res,
    output logic                out_free,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          kind,
    output logic [7:0]          payload_byte,
    output logic [15:0]         message_id,
    output logic                last
);

    logic              valid_reg;
    logic              valid_next;
    lpmd_pkg::result_t res_reg;

    assign out_free     = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign kind         = res_reg.kind;
    assign payload_byte = res_reg.payload_byte;
    assign message_id   = res_reg.message_id;
    assign last         = res_reg.last;

    always_comb
    begin
        if (res_valid)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            res_reg <= res;
    end

endmodule

@@ rtl/core/length_prefixed_message_deframer.sv @@
// path: a word accepted into the input register is handled by the framing logic, and any
// result it yields is written to the result register, from which it is taken downstream
// throughput: one word per cycle while the result register is free or being taken, set by
// the framing update between the input register and the result register
// reset: asynchronous, active low; the session opens in header phase, timer disarmed
// depends on lpmd_pkg, lpmd_cfg_regs, lpmd_in_reg, lpmd_frame_fsm, lpmd_out_reg
`timescale 1ns / 1ps

module length_prefixed_message_deframer
#(
    parameter int ID_BYTES  = lpmd_pkg::ID_BYTES_DEF,
    parameter int LEN_BYTES = lpmd_pkg::LEN_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  payload_byte,
    output logic [15:0] message_id,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    lpmd_pkg::cfg_t    cfg;
    lpmd_pkg::item_t   item;
    lpmd_pkg::result_t res;
    lpmd_pkg::status_t status;
    logic              item_valid;
    logic              consume;
    logic              res_valid;
    logic              out_free;

    lpmd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lpmd_in_reg u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .consume    (consume),
        .item_valid (item_valid),
        .item       (item)
    );

    lpmd_frame_fsm
    #(
        .ID_BYTES  (ID_BYTES),
        .LEN_BYTES (LEN_BYTES)
    )
    u_fsm
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .consume    (consume),
        .res_valid  (res_valid),
        .res        (res),
        .status     (status)
    );

    lpmd_out_reg u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_valid),
        .res          (res),
        .out_free     (out_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .payload_byte (payload_byte),
        .message_id   (message_id),
        .last         (last)
    );

`ifndef SYNTHESIS
    // a closed session stays closed until reset
    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        status.closed |=> status.closed)
        else $error("session reopened after close");

    // a closed session never arms the timer nor emits new results
    a_closed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        status.closed |-> !status.timer_armed && !res_valid)
        else $error("activity in closed session");

    // only payload words carry data; every non-payload result ends a message
    a_nonbyte_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != lpmd_pkg::KIND_BYTE |-> payload_byte == 8'd0 && last)
        else $error("malformed non-payload result");

    // close results carry no id
    a_close_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == lpmd_pkg::KIND_CLOSE |-> message_id == 16'd0)
        else $error("close result with id");
`endif

endmodule

@@ tb/sv/length_prefixed_message_deframer_tb.sv @@
// length_prefixed_message_deframer_tb: self-checking bench for the message deframer
// holds a behavioural deframer, a result queue, random valid/ready pacing and a watchdog
// depends on lpmd_pkg and length_prefixed_message_deframer
`timescale 1ns / 1ps

module length_prefixed_message_deframer_tb;

    import lpmd_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_GAP       = 16;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 100;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] message_id;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // behavioural deframer state
    cfg_t        regs;
    phase_t      phase;
    int unsigned hdr_count;
    logic [23:0] hdr_shift;
    logic [15:0] msg_id;
    logic [15:0] bytes_left;
    logic        timer_armed;
    logic [31:0] timer_count;
    result_t     expected_results[$];

    int mismatches;
    int words_sent;
    int idle_cycles;
    bit send_burst;

    length_prefixed_message_deframer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .payload_byte (payload_byte),
        .message_id   (message_id),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    function automatic void queue_result(input logic [2:0] k, input logic [7:0] b,
                                         input logic [15:0] id, input logic l);
        expected_results.push_back({k, b, id, l});
    endfunction

    function automatic void close_session();
        phase       = PH_CLOSED;
        timer_armed = 1'b0;
        timer_count = '0;
    endfunction

    // end of a message: heartbeats re-arm the timer and report their own kind with no payload byte
    function automatic void complete_message(input logic [7:0] b, input logic [2:0] plain_kind);
        phase      = PH_HEADER;
        hdr_count  = 0;
        hdr_shift  = '0;
        bytes_left = '0;
        if (msg_id == regs.heartbeat_id)
        begin
            timer_armed = 1'b1;
            timer_count = regs.timeout_ticks;
            queue_result(KIND_HEART, 8'd0, msg_id, 1'b1);
        end
        else
            queue_result(plain_kind, b, msg_id, 1'b1);
    endfunction

    function automatic void deframe_word(input logic [1:0] c, input logic [7:0] b);
        logic [31:0] full;
        logic [15:0] id;
        logic [15:0] len;
        if (phase == PH_CLOSED)
            return;
        case (c)
            CMD_LINK_ERR:
            begin
                close_session();
                queue_result(KIND_CLOSE, 8'd0, 16'd0, 1'b1);
            end
            CMD_TICK:
            begin
                if (timer_armed)
                begin
                    if (timer_count <= 32'd1)
                    begin
                        close_session();
                        queue_result(KIND_CLOSE, 8'd0, 16'd0, 1'b1);
                    end
                    else
                        timer_count--;
                end
            end
            CMD_BYTE:
            begin
                if (phase == PH_HEADER)
                begin
                    if (hdr_count < 3)
                    begin
                        hdr_shift = {hdr_shift[15:0], b};
                        hdr_count++;
                    end
                    else
                    begin
                        full      = {hdr_shift, b};
                        id        = full[31:16];
                        len       = full[15:0];
                        hdr_count = 0;
                        hdr_shift = '0;
                        msg_id    = id;
                        // id and length share one check; the id is the one reported either way
                        if (id > regs.len_limit || len > regs.len_limit)
                        begin
                            close_session();
                            queue_result(KIND_HDR_ERR, 8'd0, id, 1'b1);
                        end
                        else if (len == 16'd0)
                            complete_message(8'd0, KIND_EMPTY);
                        else
                        begin
                            bytes_left = len;
                            phase      = PH_PAYLOAD;
                        end
                    end
                end
                else
                begin
                    bytes_left--;
                    if (bytes_left == 16'd0)
                        complete_message(b, KIND_BYTE);
                    else if (msg_id != regs.heartbeat_id)
                        queue_result(KIND_BYTE, b, msg_id, 1'b0);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_word(input logic [1:0] c, input logic [7:0] b);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        data_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        if (c == CMD_BYTE || (c == CMD_TICK && timer_armed))
            words_sent++;
        deframe_word(c, b);
    endtask

    // drop valid and let the pipe run dry before touching registers or pausing
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LEN_LIMIT:     regs.len_limit     = value[15:0];
            REG_HEARTBEAT_ID:  regs.heartbeat_id  = value[15:0];
            REG_TIMEOUT_TICKS: regs.timeout_ticks = value;
            default:
            begin
            end
        endcase
    endtask

    // upper bits of the 16-bit registers carry junk that must be ignored
    task automatic set_registers(input logic [15:0] lim, input logic [15:0] hb,
                                 input logic [31:0] ticks);
        wait_idle();
        write_register(REG_LEN_LIMIT, {16'($urandom()), lim});
        write_register(REG_HEARTBEAT_ID, {16'($urandom()), hb});
        write_register(REG_TIMEOUT_TICKS, ticks);
    endtask

    // a tick that would expire the timer is swapped for an unused command
    task automatic send_noise();
        if ($urandom_range(0, 1) == 0 && !(timer_armed && timer_count <= 32'd1))
            send_word(CMD_TICK, 8'($urandom()));
        else
            send_word(CMD_UNUSED, 8'($urandom()));
    endtask

    task automatic send_header(input logic [15:0] id, input logic [15:0] len, input bit noisy);
        logic [31:0] header;
        header = {id, len};
        for (int i = 3; i >= 0; i--)
        begin
            if (noisy && $urandom_range(0, 5) == 0)
                send_noise();
            send_word(CMD_BYTE, header[8*i +: 8]);
        end
    endtask

    task automatic send_message(input logic [15:0] id, input logic [15:0] len, input bit noisy);
        send_header(id, len, noisy);
        for (int n = 0; n < len; n++)
        begin
            if (noisy && $urandom_range(0, 7) == 0)
                send_noise();
            send_word(CMD_BYTE, 8'($urandom()));
        end
    endtask

    task automatic send_random_message();
        logic [15:0] id;
        logic [15:0] len;
        int          pick;
        int          cap;
        pick = $urandom_range(0, 15);
        if (pick < 4 && regs.heartbeat_id <= regs.len_limit)
            id = regs.heartbeat_id;
        else if (pick == 4)
            id = 16'd0;
        else if (pick == 5)
            id = regs.len_limit;
        else
            id = 16'($urandom_range(0, regs.len_limit));
        pick = $urandom_range(0, 95);
        cap  = (regs.len_limit < 16'd12) ? regs.len_limit : 12;
        if (pick < 12)
            len = 16'd0;
        else if (pick == 12)
            len = (regs.len_limit < 16'd300) ? regs.len_limit : 16'($urandom_range(256, 300));
        else if (pick == 13 && regs.len_limit <= 16'd64)
            len = regs.len_limit;
        else
            len = 16'($urandom_range(0, cap));
        send_burst = ($urandom_range(0, 3) == 0);
        send_message(id, len, $urandom_range(0, 2) == 0);
    endtask

    task automatic test_directed_framing();
        send_burst = 1'b0;
        send_header(16'd0, 16'd0, 1'b0);
        send_header(LEN_LIMIT_RST, 16'd2, 1'b0);
        send_word(CMD_BYTE, 8'h00);
        send_word(CMD_BYTE, 8'hFF);
        send_word(CMD_TICK, 8'hFF);
        send_word(CMD_UNUSED, 8'hFF);
        send_header(HEARTBEAT_ID_RST, 16'd0, 1'b0);
        send_word(CMD_TICK, 8'h00);
        // heartbeat with a payload, ticks and unused words inside the header
        send_word(CMD_BYTE, HEARTBEAT_ID_RST[15:8]);
        send_word(CMD_TICK, 8'h5A);
        send_word(CMD_BYTE, HEARTBEAT_ID_RST[7:0]);
        send_word(CMD_UNUSED, 8'h00);
        send_word(CMD_BYTE, 8'h00);
        send_word(CMD_BYTE, 8'h01);
        send_word(CMD_BYTE, 8'hA5);
    endtask

    task automatic test_register_extremes();
        send_burst = 1'b0;
        set_registers(16'd0, 16'd0, 32'hFFFF_FFFF);
        send_header(16'd0, 16'd0, 1'b0);
        set_registers(16'hFFFF, 16'hFFFF, 32'd2);
        send_message(16'hFFFF, 16'd1, 1'b0);
        send_message(16'hFFFE, 16'd3, 1'b0);
        send_word(CMD_TICK, 8'h81);
        send_header(16'hFFFF, 16'd0, 1'b0);
        send_word(CMD_TICK, 8'h7E);
    endtask

    task automatic test_random_traffic(input logic [15:0] lim, input logic [15:0] hb,
                                       input logic [31:0] ticks, input int budget);
        int start;
        bit paused;
        set_registers(lim, hb, ticks);
        start  = words_sent;
        paused = 1'b0;
        while (words_sent - start < budget)
        begin
            // hold off once mid-phase until every pending result is out
            if (!paused && words_sent - start >= budget / 2)
            begin
                wait_idle();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_random_message();
        end
    endtask

    // a closed session stays closed until reset, so this has to come last
    task automatic test_session_close();
        logic [15:0] lim;
        int          cause;
        lim = 16'($urandom_range(0, 4000));
        set_registers(lim, 16'($urandom_range(0, lim)), 32'($urandom_range(0, 3)));
        repeat (3) send_random_message();
        send_burst = 1'b0;
        cause = $urandom_range(0, 4);
        case (cause)
            0: send_header(16'($urandom_range(lim + 1, 65535)),
                           16'($urandom_range(lim + 1, 65535)), 1'b0);
            1: send_header(16'($urandom_range(lim + 1, 65535)),
                           16'($urandom_range(0, lim)), 1'b0);
            2: send_header(16'($urandom_range(0, lim)),
                           16'($urandom_range(lim + 1, 65535)), 1'b0);
            3:
            begin
                send_header(regs.heartbeat_id, 16'd0, 1'b0);
                while (phase != PH_CLOSED)
                    send_word(CMD_TICK, 8'($urandom()));
            end
            default:
            begin
                repeat ($urandom_range(0, 3)) send_word(CMD_BYTE, 8'($urandom()));
                send_word(CMD_LINK_ERR, 8'($urandom()));
            end
        endcase
        // everything after the close must be swallowed
        repeat (8) send_word(2'($urandom_range(0, 3)), 8'($urandom()));
    endtask

    initial
    begin : stimulus
        logic [15:0] lim;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cmd         = CMD_BYTE;
        data_byte   = 8'd0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_LEN_LIMIT;
        cfg_data    = 32'd0;
        regs        = {LEN_LIMIT_RST, HEARTBEAT_ID_RST, TIMEOUT_TICKS_RST};
        phase       = PH_HEADER;
        hdr_count   = 0;
        hdr_shift   = '0;
        msg_id      = '0;
        bytes_left  = '0;
        timer_armed = 1'b0;
        timer_count = '0;
        mismatches  = 0;
        words_sent  = 0;
        send_burst  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_framing();
        test_register_extremes();
        test_random_traffic(LEN_LIMIT_RST, HEARTBEAT_ID_RST, TIMEOUT_TICKS_RST, 400);
        test_random_traffic(16'hFFFF, 16'($urandom()), 32'hFFFF_FFFF, 400);
        lim = 16'($urandom_range(1, 300));
        test_random_traffic(lim, 16'($urandom_range(0, lim)), 32'($urandom_range(1, 6)), 400);
        lim = 16'($urandom_range(3, 15));
        test_random_traffic(lim, 16'($urandom_range(0, lim)), 32'($urandom_range(2, 40)), 400);
        test_session_close();

        @(negedge clk);
        in_valid <= 1'b0;
        for (int w = 0; w < STALL_LIMIT && expected_results.size() != 0; w++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : result_sink
        int stall;
        int taken;
        bit recv_burst;
        out_ready  = 1'b0;
        taken      = 0;
        recv_burst = 1'b0;
        forever
        begin
            if (taken % 64 == 0)
                recv_burst = ($urandom_range(0, 3) == 0);
            stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(rst_n && out_valid));
            taken++;
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected word kind %0d id %0d byte %0d last %0d",
                                          kind, message_id, payload_byte, last));
            else
            begin
                want = expected_results.pop_front();
                if (kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d (id %0d)",
                                              kind, want.kind, want.message_id));
                if (payload_byte !== want.payload_byte)
                    report_mismatch($sformatf("payload_byte %0d, want %0d (id %0d)",
                                              payload_byte, want.payload_byte, want.message_id));
                if (message_id !== want.message_id)
                    report_mismatch($sformatf("message_id %0d, want %0d",
                                              message_id, want.message_id));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0d, want %0d (id %0d)",
                                              last, want.last, want.message_id));
            end
        end
    end

    // no handshake on any channel for too long means the block has hung
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

@@ sim.f @@
rtl/core/lpmd_pkg.sv
rtl/core/lpmd_cfg_regs.sv
rtl/core/lpmd_in_reg.sv
rtl/core/lpmd_frame_fsm.sv
rtl/core/lpmd_out_reg.sv
rtl/core/length_prefixed_message_deframer.sv
tb/sv/length_prefixed_message_deframer_tb.sv
